### rtl/core/tmfl_pkg.sv
// tmfl_pkg: item types, operation codes, controller states and the
// command/status groups shared by the controller and the datapath.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmfl_pkg;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// byte address of the rate register
	localparam logic [1:0] ADDR_RATE = 2'd0;

	localparam logic [1:0] OP_WRITE_REWARD = 2'd0;
	localparam logic [1:0] OP_REBUILD      = 2'd1;
	localparam logic [1:0] OP_LEARN        = 2'd2;
	localparam logic [1:0] OP_READ_Q       = 2'd3;

	typedef struct packed {
		logic        [1:0]  operation;
		logic        [5:0]  node;
		logic        [1:0]  action;
		logic        [8:0]  child;
		logic        [7:0]  reward_slot;
		logic signed [15:0] reward_value;
	} in_t;

	typedef struct packed {
		logic        [16:0] prediction_error;
		logic signed [31:0] q_value;
	} out_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_RW,
		ST_QRD,
		ST_QRD_CAP,
		ST_ERR_RD,
		ST_ERR_CAP,
		ST_PJ_RD,
		ST_PJ_MUL,
		ST_PJ_WR,
		ST_CQ_START,
		ST_VAL_RD,
		ST_VAL_CAP,
		ST_MUL,
		ST_ACC,
		ST_Q_WR,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rw_write;
		logic q_rd_item;
		logic q_cap;
		logic prob_rd_js;
		logic err_cap;
		logic prob_rd_j;
		logic pj_mul;
		logic pj_wr;
		logic cq_init;
		logic val_rd;
		logic val_cap;
		logic mul;
		logic acc;
		logic q_wr;
		logic step_up;
		logic step_rebuild;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] op;
		logic       item_ok;
		logic       j_last;
		logic       k_last;
		logic       child_internal;
		logic       a_last;
		logic       p_zero;
		logic       out_busy;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/tree_mdp_forward_learner_unit.sv
// tree_mdp_forward_learner_unit: top level with the register port
// depends on tmfl_pkg, tmfl_ctrl and tmfl_dpath
`timescale 1ns / 1ps
`default_nettype none

// forward learner for an implicit complete tree mdp. each item carries an
// operation: write a leaf reward, rebuild every q value from the highest
// internal node down to the root, learn an observed transition (moves that
// child's probability towards one, shrinks its siblings, then recomputes the
// q values up the path to the root), or read one q value. every item gives
// exactly one result item, held in its own output register so that the
// next item can be taken while it waits. items are handled one at a time by
// a sequencer over three single-port memories, with separate multipliers
// for the probability update and the q sums. after reset a clearing pass
// loads the reset values, with in_ready held low; register writes are taken
// throughout. the rate register sits at byte address 0.
module tree_mdp_forward_learner_unit #(
	parameter int ACTION_COUNT   = 2,
	parameter int BRANCH         = 2,
	parameter int INTERNAL_NODES = 5,
	parameter int REWARD_SLOTS   = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  tmfl_pkg::in_t  in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output tmfl_pkg::out_t out_data,
	input  wire            psel,
	input  wire            penable,
	input  wire            pwrite,
	input  wire     [1:0]  paddr,
	input  wire     [31:0] pwdata,
	output logic    [31:0] prdata,
	output logic           pready
);
	import tmfl_pkg::*;

	logic [16:0] rate_q;
	cmd_t        cmd;
	sts_t        sts;

	// learning rate register, unsigned q1.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 17'd32768;
		end else if (psel && penable && pwrite && paddr == ADDR_RATE) begin
			rate_q <= pwdata[16:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = {15'd0, rate_q};

	tmfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmfl_dpath #(
		.ACTION_COUNT   (ACTION_COUNT),
		.BRANCH         (BRANCH),
		.INTERNAL_NODES (INTERNAL_NODES),
		.REWARD_SLOTS   (REWARD_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.rate      (rate_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

### rtl/core/tmfl_ctrl.sv
// tmfl_ctrl: sequencing state machine for the forward learner
// depends on tmfl_pkg; drives the datapath by command, reads its status
`timescale 1ns / 1ps
`default_nettype none

module tmfl_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  tmfl_pkg::sts_t sts,
	output tmfl_pkg::cmd_t cmd
);
	import tmfl_pkg::*;

	ctl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (sts.op)
					OP_WRITE_REWARD: state_nxt = ST_RW;
					OP_REBUILD:      state_nxt = ST_CQ_START;
					OP_LEARN:        state_nxt = sts.item_ok ? ST_ERR_RD : ST_DONE;
					OP_READ_Q:       state_nxt = sts.item_ok ? ST_QRD : ST_DONE;
					default:         state_nxt = ST_DONE;
				endcase
			end
			ST_RW:       state_nxt = ST_DONE;
			ST_QRD:      state_nxt = ST_QRD_CAP;
			ST_QRD_CAP:  state_nxt = ST_DONE;
			ST_ERR_RD:   state_nxt = ST_ERR_CAP;
			ST_ERR_CAP:  state_nxt = ST_PJ_RD;
			ST_PJ_RD:    state_nxt = ST_PJ_MUL;
			ST_PJ_MUL:   state_nxt = ST_PJ_WR;
			ST_PJ_WR: begin
				state_nxt = sts.j_last ? ST_CQ_START : ST_PJ_RD;
			end
			ST_CQ_START: state_nxt = ST_VAL_RD;
			ST_VAL_RD:   state_nxt = ST_VAL_CAP;
			ST_VAL_CAP: begin
				state_nxt = (sts.child_internal && !sts.k_last) ? ST_VAL_RD : ST_MUL;
			end
			ST_MUL:      state_nxt = ST_ACC;
			ST_ACC: begin
				state_nxt = sts.j_last ? ST_Q_WR : ST_VAL_RD;
			end
			ST_Q_WR: begin
				if (sts.op == OP_REBUILD) begin
					state_nxt = (sts.a_last && sts.p_zero) ? ST_DONE : ST_CQ_START;
				end else begin
					state_nxt = sts.p_zero ? ST_DONE : ST_CQ_START;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR:    cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DISPATCH: ;
			ST_RW:       cmd.rw_write = 1'b1;
			ST_QRD:      cmd.q_rd_item = 1'b1;
			ST_QRD_CAP:  cmd.q_cap = 1'b1;
			ST_ERR_RD:   cmd.prob_rd_js = 1'b1;
			ST_ERR_CAP:  cmd.err_cap = 1'b1;
			ST_PJ_RD:    cmd.prob_rd_j = 1'b1;
			ST_PJ_MUL:   cmd.pj_mul = 1'b1;
			ST_PJ_WR:    cmd.pj_wr = 1'b1;
			ST_CQ_START: cmd.cq_init = 1'b1;
			ST_VAL_RD:   cmd.val_rd = 1'b1;
			ST_VAL_CAP:  cmd.val_cap = 1'b1;
			ST_MUL:      cmd.mul = 1'b1;
			ST_ACC:      cmd.acc = 1'b1;
			ST_Q_WR: begin
				cmd.q_wr = 1'b1;
				if (sts.op == OP_REBUILD) begin
					cmd.step_rebuild = !(sts.a_last && sts.p_zero);
				end else begin
					cmd.step_up = !sts.p_zero;
				end
			end
			ST_DONE:     cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/tmfl_dpath.sv
// tmfl_dpath: probability, q and reward memories, index registers,
// multiply-accumulate and the output register; depends on tmfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmfl_dpath #(
	parameter int ACTION_COUNT   = 2,
	parameter int BRANCH         = 2,
	parameter int INTERNAL_NODES = 5,
	parameter int REWARD_SLOTS   = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  tmfl_pkg::in_t  in_data,
	input  wire     [16:0] rate,
	input  wire            out_ready,
	output logic           out_valid,
	output tmfl_pkg::out_t out_data,
	input  tmfl_pkg::cmd_t cmd,
	output tmfl_pkg::sts_t sts
);
	import tmfl_pkg::*;

	localparam int NAB    = ACTION_COUNT * BRANCH;
	localparam int PROB_D = INTERNAL_NODES * NAB;
	localparam int Q_D    = INTERNAL_NODES * ACTION_COUNT;
	localparam int D_MAX  = (PROB_D > REWARD_SLOTS) ? PROB_D : REWARD_SLOTS;
	localparam int PA_W   = $clog2(PROB_D);
	localparam int QA_W   = $clog2(Q_D);
	localparam int RA_W   = (REWARD_SLOTS > 1) ? $clog2(REWARD_SLOTS) : 1;
	localparam int P_W    = (INTERNAL_NODES > 1) ? $clog2(INTERNAL_NODES) : 1;
	localparam int A_W    = $clog2(ACTION_COUNT);
	localparam int J_W    = $clog2(BRANCH);
	localparam int C_W    = $clog2(PROB_D + 1);
	localparam int CL_W   = $clog2(D_MAX);
	localparam logic [16:0] PROB_RST = 17'(65536 / BRANCH);
	localparam logic [16:0] RCP_BR   = 17'(65536 / BRANCH);
	localparam logic [16:0] RCP_NAB  = 17'(65536 / NAB);

	// memories
	logic        [16:0] prob_mem [PROB_D];
	logic signed [31:0] q_mem    [Q_D];
	logic signed [15:0] rw_mem   [REWARD_SLOTS];
	logic        [16:0] prob_rd_q;
	logic signed [31:0] q_rd_q;
	logic signed [15:0] rw_rd_q;

	// control registers
	logic [CL_W-1:0] clr_q;
	logic [P_W-1:0]  p_q;
	logic [A_W-1:0]  a_q;
	logic [J_W-1:0]  j_q;
	logic [A_W-1:0]  k_q;
	logic [J_W-1:0]  js_q;
	logic            out_valid_q;

	// payload registers
	in_t                item_q;
	logic        [16:0] err_q;
	logic        [16:0] pv_q;
	logic        [33:0] pprod_q;
	logic signed [31:0] val_q;
	logic signed [49:0] mprod_q;
	logic signed [35:0] sum_q;
	logic        [16:0] res_err_q;
	logic signed [31:0] res_q_q;
	logic        [16:0] out_err_q;
	logic signed [31:0] out_qv_q;

	// learned slot: (child + BRANCH - 1) mod BRANCH by reciprocal
	logic [9:0]  js_x;
	logic [26:0] js_m;
	logic [9:0]  js_r;
	logic [9:0]  js_r2;
	always_comb begin
		js_x  = 10'(in_data.child) + 10'(BRANCH - 1);
		js_m  = 27'(js_x) * 27'(RCP_BR);
		js_r  = js_x - 10'(int'(js_m[26:16]) * BRANCH);
		js_r2 = (int'(js_r) >= BRANCH) ? 10'(int'(js_r) - BRANCH) : js_r;
	end

	// parent of p: p-1 split by NAB, remainder split by BRANCH
	logic [5:0]  up_x;
	logic [22:0] up_m;
	logic [5:0]  up_q;
	logic [5:0]  up_r;
	logic [5:0]  up_qc;
	logic [5:0]  up_rc;
	logic [22:0] ua_m;
	logic [5:0]  ua_q;
	logic [5:0]  ua_r;
	logic [5:0]  ua_qc;
	always_comb begin
		up_x  = 6'(p_q) - 6'd1;
		up_m  = 23'(up_x) * 23'(RCP_NAB);
		up_q  = up_m[21:16];
		up_r  = 6'(int'(up_x) - int'(up_q) * NAB);
		up_qc = (int'(up_r) >= NAB) ? up_q + 6'd1 : up_q;
		up_rc = (int'(up_r) >= NAB) ? 6'(int'(up_r) - NAB) : up_r;
		ua_m  = 23'(up_rc) * 23'(RCP_BR);
		ua_q  = ua_m[21:16];
		ua_r  = 6'(int'(up_rc) - int'(ua_q) * BRANCH);
		ua_qc = (int'(ua_r) >= BRANCH) ? ua_q + 6'd1 : ua_q;
	end

	// child of (p, a, j)
	logic [C_W-1:0] c_idx;
	logic           c_internal;
	logic           leaf_ok;
	int             leaf_slot;
	always_comb begin
		c_idx      = C_W'(int'(p_q) * NAB + int'(a_q) * BRANCH + int'(j_q) + 1);
		c_internal = int'(c_idx) < INTERNAL_NODES;
		leaf_slot  = int'(c_idx) - INTERNAL_NODES;
		leaf_ok    = !c_internal && (leaf_slot < REWARD_SLOTS);
	end

	logic [16:0] rate_eff;
	assign rate_eff = (rate > ONE_Q16) ? ONE_Q16 : rate;

	// memory ports
	logic              prob_we, prob_re;
	logic [PA_W-1:0]   prob_wa, prob_ra;
	logic [16:0]       prob_wd;
	logic              q_we, q_re;
	logic [QA_W-1:0]   q_wa, q_ra;
	logic signed [31:0] q_wd;
	logic              rw_we, rw_re;
	logic [RA_W-1:0]   rw_wa, rw_ra;
	logic signed [15:0] rw_wd;
	logic [PA_W-1:0]   prob_base;
	logic signed [31:0] sum_sat;

	always_comb begin
		prob_base = PA_W'((int'(p_q) * ACTION_COUNT + int'(a_q)) * BRANCH);
		if (sum_q > 36'sd2147483647)       sum_sat = 32'sh7fffffff;
		else if (sum_q < -36'sd2147483648) sum_sat = 32'sh80000000;
		else                               sum_sat = sum_q[31:0];

		prob_we = 1'b0;
		prob_wa = prob_base + PA_W'(j_q);
		prob_wd = '0;
		if (cmd.clr_step) begin
			prob_we = int'(clr_q) < PROB_D;
			prob_wa = PA_W'(clr_q);
			prob_wd = PROB_RST;
		end else if (cmd.pj_wr) begin
			prob_we = 1'b1;
			prob_wd = (j_q == js_q) ? 17'({1'b0, pv_q} + pprod_q[33:16]) : pprod_q[32:16];
		end
		prob_re = cmd.prob_rd_js || cmd.prob_rd_j || cmd.val_rd;
		prob_ra = prob_base + PA_W'(cmd.prob_rd_js ? js_q : j_q);

		q_we = 1'b0;
		q_wa = QA_W'(int'(p_q) * ACTION_COUNT + int'(a_q));
		q_wd = sum_sat;
		if (cmd.clr_step) begin
			q_we = int'(clr_q) < Q_D;
			q_wa = QA_W'(clr_q);
			q_wd = '0;
		end else if (cmd.q_wr) begin
			q_we = 1'b1;
		end
		q_re = cmd.q_rd_item || (cmd.val_rd && c_internal);
		if (cmd.q_rd_item) begin
			q_ra = QA_W'(int'(item_q.node) * ACTION_COUNT + int'(item_q.action));
		end else begin
			q_ra = QA_W'(int'(c_idx) * ACTION_COUNT + int'(k_q));
		end

		rw_we = 1'b0;
		rw_wa = RA_W'(item_q.reward_slot);
		rw_wd = item_q.reward_value;
		if (cmd.clr_step) begin
			rw_we = int'(clr_q) < REWARD_SLOTS;
			rw_wa = RA_W'(clr_q);
			rw_wd = '0;
		end else if (cmd.rw_write) begin
			rw_we = int'(item_q.reward_slot) < REWARD_SLOTS;
		end
		rw_re = cmd.val_rd && leaf_ok;
		rw_ra = RA_W'(leaf_slot);
	end

	always_ff @(posedge clk) begin
		if (prob_we) prob_mem[prob_wa] <= prob_wd;
		if (prob_re) prob_rd_q <= prob_mem[prob_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_wa] <= q_wd;
		if (q_re) q_rd_q <= q_mem[q_ra];
	end

	always_ff @(posedge clk) begin
		if (rw_we) rw_mem[rw_wa] <= rw_wd;
		if (rw_re) rw_rd_q <= rw_mem[rw_ra];
	end

	// index counters and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			p_q         <= '0;
			a_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			js_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + CL_W'(1);
			if (cmd.load) begin
				js_q <= js_r2[J_W-1:0];
				if (in_data.operation == OP_REBUILD) begin
					p_q <= P_W'(INTERNAL_NODES - 1);
					a_q <= '0;
				end else begin
					p_q <= in_data.node[P_W-1:0];
					a_q <= in_data.action[A_W-1:0];
				end
			end
			if (cmd.err_cap || cmd.cq_init) j_q <= '0;
			if (cmd.pj_wr || cmd.acc) j_q <= j_q + J_W'(1);
			if (cmd.cq_init) k_q <= '0;
			if (cmd.val_cap) begin
				k_q <= (c_internal && int'(k_q) != ACTION_COUNT - 1) ? k_q + A_W'(1) : '0;
			end
			if (cmd.step_rebuild) begin
				if (int'(a_q) == ACTION_COUNT - 1) begin
					a_q <= '0;
					p_q <= p_q - P_W'(1);
				end else begin
					a_q <= a_q + A_W'(1);
				end
			end
			if (cmd.step_up) begin
				p_q <= P_W'(up_qc);
				a_q <= A_W'(ua_qc);
			end
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= in_data;
			res_err_q <= '0;
			res_q_q   <= '0;
		end
		if (cmd.q_cap) res_q_q <= q_rd_q;
		if (cmd.err_cap) begin
			err_q     <= ONE_Q16 - prob_rd_q;
			res_err_q <= ONE_Q16 - prob_rd_q;
		end
		if (cmd.pj_mul) begin
			pv_q <= prob_rd_q;
			if (j_q == js_q) pprod_q <= 34'(err_q) * 34'(rate_eff);
			else             pprod_q <= 34'(prob_rd_q) * 34'(ONE_Q16 - rate_eff);
		end
		if (cmd.cq_init) sum_q <= '0;
		if (cmd.val_cap) begin
			if (c_internal) begin
				if (k_q == '0 || q_rd_q > val_q) val_q <= q_rd_q;
			end else if (leaf_ok) begin
				val_q <= {rw_rd_q, 16'd0};
			end else begin
				val_q <= '0;
			end
		end
		if (cmd.mul) mprod_q <= $signed({1'b0, prob_rd_q}) * val_q;
		if (cmd.acc) sum_q <= sum_q + 36'(mprod_q >>> 16);
		// result register, held while the item waits at the output
		if (cmd.out_load) begin
			out_err_q <= res_err_q;
			out_qv_q  <= res_q_q;
		end
	end

	always_comb begin
		sts                = '0;
		sts.clr_last       = int'(clr_q) == D_MAX - 1;
		sts.op             = item_q.operation;
		sts.item_ok        = (int'(item_q.node) < INTERNAL_NODES)
		                  && (int'(item_q.action) < ACTION_COUNT);
		sts.j_last         = int'(j_q) == BRANCH - 1;
		sts.k_last         = int'(k_q) == ACTION_COUNT - 1;
		sts.child_internal = c_internal;
		sts.a_last         = int'(a_q) == ACTION_COUNT - 1;
		sts.p_zero         = p_q == '0;
		sts.out_busy       = out_valid_q && !out_ready;
	end

	assign out_valid                 = out_valid_q;
	assign out_data.prediction_error = out_err_q;
	assign out_data.q_value          = out_qv_q;

endmodule

`default_nettype wire

### test/tb_tree_mdp_forward_learner_unit.sv
// tb_tree_mdp_forward_learner_unit: self-checking bench for the tree mdp forward learner
// depends on tmfl_pkg and tree_mdp_forward_learner_unit; predicts every result in-bench
`timescale 1ns / 1ps

module tb_tree_mdp_forward_learner_unit;
	import tmfl_pkg::*;

	// block shape, kept equal to the defaults of the top level
	localparam int N_ACT  = 2;
	localparam int N_BR   = 2;
	localparam int N_INT  = 5;
	localparam int N_SLOT = 16;
	localparam int FANOUT = N_ACT * N_BR;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RAND_PER_PHASE = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tree_mdp_forward_learner_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the learner state
	int unsigned trans_p [N_INT][N_ACT][N_BR];
	longint tree_q [N_INT][N_ACT];
	int leaf_reward [N_SLOT];
	int unsigned rate_reg;

	in_t pending_items[$];
	out_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int op_count [4];
	bit quiet = 1'b0;
	longint cycles = 0;

	// value seen from above: best q of an internal child, reward of a leaf
	function automatic longint best_value(int unsigned c);
		longint best;
		if (c < N_INT) begin
			best = tree_q[c][0];
			for (int a = 1; a < N_ACT; a++)
				if (tree_q[c][a] > best) best = tree_q[c][a];
			return best;
		end
		c -= N_INT;
		if (c < N_SLOT) return longint'(leaf_reward[c]) * 65536;
		return 0;
	endfunction

	// sum of floored products, saturated to 32 bits signed
	function automatic void node_q(int unsigned p, int unsigned a);
		int unsigned first;
		longint sum;
		first = p * FANOUT + a * N_BR + 1;
		sum = 0;
		for (int j = 0; j < N_BR; j++)
			sum += (longint'(trans_p[p][a][j]) * best_value(first + j)) >>> 16;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		tree_q[p][a] = sum;
	endfunction

	function automatic void refresh_path(int unsigned p, int unsigned a);
		forever begin
			node_q(p, a);
			if (p == 0) return;
			a = ((p - 1) % FANOUT) / N_BR;
			p = (p - 1) / FANOUT;
		end
	endfunction

	function automatic out_t predict_result(in_t it);
		out_t r;
		bit ok;
		longint unsigned rate, err, pv;
		int unsigned js;
		r = '0;
		ok = it.node < N_INT && it.action < N_ACT;
		op_count[it.operation]++;
		case (it.operation)
			OP_WRITE_REWARD: begin
				if (it.reward_slot < N_SLOT) leaf_reward[it.reward_slot] = it.reward_value;
			end
			OP_REBUILD: begin
				for (int p = N_INT - 1; p >= 0; p--)
					for (int a = 0; a < N_ACT; a++) node_q(p, a);
			end
			OP_LEARN: begin
				if (ok) begin
					// rates above one act as one
					rate = (rate_reg > 65536) ? 65536 : rate_reg;
					js = (it.child + N_BR - 1) % N_BR;
					err = 65536 - trans_p[it.node][it.action][js];
					for (int j = 0; j < N_BR; j++) begin
						pv = trans_p[it.node][it.action][j];
						if (j == js) pv += (rate * err) >> 16;
						else pv = (pv * (65536 - rate)) >> 16;
						trans_p[it.node][it.action][j] = pv & 64'h1FFFF;
					end
					refresh_path(it.node, it.action);
					r.prediction_error = err[16:0];
				end
			end
			default: begin
				if (ok) r.q_value = tree_q[it.node][it.action][31:0];
			end
		endcase
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	// sender: next item from the pending queue, with random gaps
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result, stalls in bursts and once for a long stretch
	int stall_left = 0;
	int long_hold = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result q_value", out_data.q_value, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.prediction_error !== want.prediction_error)
						report("prediction_error", out_data.prediction_error,
							want.prediction_error);
					if (out_data.q_value !== want.q_value)
						report("q_value", out_data.q_value, want.q_value);
				end
				results_seen++;
			end
			if (!long_hold_done && results_seen == 300) begin
				// block fills up while the sender keeps offering
				long_hold_done <= 1'b1;
				long_hold <= 400;
				out_ready <= 1'b0;
			end else if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				out_ready <= (long_hold == 1);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic in_t make_item(logic [1:0] op, int node, int act, int child,
		int slot, int value);
		in_t it;
		it.operation = op;
		it.node = node;
		it.action = act;
		it.child = child;
		it.reward_slot = slot;
		it.reward_value = value;
		return it;
	endfunction

	// random item, mostly well formed with a share of out-of-range fields
	function automatic in_t random_item();
		in_t it;
		int pick;
		it = in_t'({$urandom(), $urandom()});
		pick = $urandom_range(0, 99);
		if (pick < 25) it.operation = OP_WRITE_REWARD;
		else if (pick < 32) it.operation = OP_REBUILD;
		else if (pick < 75) it.operation = OP_LEARN;
		else it.operation = OP_READ_Q;
		if ($urandom_range(0, 9) != 0) it.node = $urandom_range(0, N_INT - 1);
		if ($urandom_range(0, 9) != 0) it.action = $urandom_range(0, N_ACT - 1);
		if ($urandom_range(0, 4) != 0)
			it.child = it.node * FANOUT + it.action * N_BR + $urandom_range(0, N_BR - 1) + 1;
		if ($urandom_range(0, 9) != 0) it.reward_slot = $urandom_range(0, N_SLOT - 1);
		case ($urandom_range(0, 9))
			0: it.reward_value = 16'sh7FFF;
			1: it.reward_value = 16'sh8000;
			2: it.reward_value = $urandom_range(0, 7) - 4;
			default: ;
		endcase
		return it;
	endfunction

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic write_rate(logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_RATE;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rate_reg = value & 32'h1FFFF;
	endtask

	initial begin
		logic [31:0] rates [6];
		for (int p = 0; p < N_INT; p++)
			for (int a = 0; a < N_ACT; a++) begin
				tree_q[p][a] = 0;
				for (int j = 0; j < N_BR; j++) trans_p[p][a][j] = 65536 / N_BR;
			end
		foreach (leaf_reward[s]) leaf_reward[s] = 0;
		foreach (op_count[i]) op_count[i] = 0;
		rate_reg = 32768;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reward extremes, ignored slots, learns incl. child zero,
		// bad node and action, rebuild and reads
		pending_items.push_back(make_item(OP_READ_Q, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_WRITE_REWARD, 0, 0, 0, 0, 32767));
		pending_items.push_back(make_item(OP_WRITE_REWARD, 0, 0, 0, 1, -32768));
		pending_items.push_back(make_item(OP_WRITE_REWARD, 0, 0, 0, 15, -1));
		pending_items.push_back(make_item(OP_WRITE_REWARD, 0, 0, 0, 16, 555));
		pending_items.push_back(make_item(OP_WRITE_REWARD, 63, 3, 511, 255, 1234));
		pending_items.push_back(make_item(OP_REBUILD, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 1, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_LEARN, 1, 0, 5, 0, 0));
		pending_items.push_back(make_item(OP_LEARN, 1, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_LEARN, 4, 1, 511, 255, -1));
		pending_items.push_back(make_item(OP_LEARN, 0, 1, 3, 0, 0));
		pending_items.push_back(make_item(OP_LEARN, 63, 0, 5, 0, 0));
		pending_items.push_back(make_item(OP_LEARN, 1, 3, 5, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 63, 3, 0, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 2, 3, 0, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 4, 1, 0, 0, 0));
		pending_items.push_back(make_item(OP_READ_Q, 0, 1, 0, 0, 0));
		pending_items.push_back(make_item(OP_REBUILD, 63, 3, 511, 255, -1));
		pending_items.push_back(make_item(OP_READ_Q, 0, 0, 0, 0, 0));
		wait_drained();

		// learning rate settings: reset value, zero, one, above one, tiny, random
		rates[0] = 32768;
		rates[1] = 0;
		rates[2] = 65536;
		rates[3] = 32'hFFFF_FFFF;
		rates[4] = 1;
		rates[5] = $urandom_range(0, 131071);
		for (int ph = 0; ph < 6; ph++) begin
			write_rate(rates[ph]);
			if (ph == 5) quiet = 1'b1;
			for (int i = 0; i < RAND_PER_PHASE; i++) pending_items.push_back(random_item());
			wait_drained();
		end
		repeat (300) @(posedge clk);

		$display("covered %0d reward writes, %0d rebuilds, %0d learns, %0d reads",
			op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("over six learning rates incl. zero, one and above one; %0d results checked",
			results_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### files.f
rtl/core/tmfl_pkg.sv
rtl/core/tmfl_ctrl.sv
rtl/core/tmfl_dpath.sv
rtl/core/tree_mdp_forward_learner_unit.sv
test/tb_tree_mdp_forward_learner_unit.sv
